// ----- src/aled_pkg.sv -----
package aled_pkg;

   localparam int MAX_BYTES = 512;
   localparam int ADDR_W = 9;
   localparam int COUNT_W = 10;
   localparam int TICK_W = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [7:0] byte_type;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_ZERO = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_ONE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEATS = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_BITS,
      PH_GAP,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [15:0] period_ticks;
      logic [15:0] high_zero_ticks;
      logic [15:0] high_one_ticks;
      tick_type reset_ticks;
      logic [7:0] frame_repeats;
   } cfg_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic accepted;
      logic done_res;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      addr_type wr_addr;
      byte_type wr_data;
      logic rd_en;
      addr_type rd_addr;
   } ram_req_type;

endpackage

// ----- src/aled_ram.sv -----
module aled_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/aled_csr.sv -----
module aled_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aled_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [aled_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output aled_pkg::cfg_type                 cfg
);

   import aled_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PERIOD:      cfg_in.period_ticks = csr_wdata[15:0];
            CSR_HIGH_ZERO:   cfg_in.high_zero_ticks = csr_wdata[15:0];
            CSR_HIGH_ONE:    cfg_in.high_one_ticks = csr_wdata[15:0];
            CSR_RESET_TICKS: cfg_in.reset_ticks = csr_wdata[TICK_W-1:0];
            CSR_REPEATS:     cfg_in.frame_repeats = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks <= 16'd225;
         cfg_ff.high_zero_ticks <= 16'd63;
         cfg_ff.high_one_ticks <= 16'd126;
         cfg_ff.reset_ticks <= 20'd18000;
         cfg_ff.frame_repeats <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

endmodule

// ----- src/aled_core.sv -----
module aled_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic [1:0]                    req_kind,
   input  aled_pkg::addr_type            req_index,
   input  aled_pkg::byte_type            req_byte_value,
   input  aled_pkg::count_type           req_count,
   input  aled_pkg::cfg_type             cfg,
   input  aled_pkg::byte_type            ram_rd_data,
   output aled_pkg::ram_req_type         ram_req,
   output aled_pkg::rsp_type             rsp
);

   import aled_pkg::*;

   phase_type phase_ff, phase_in;
   tick_type  tick_ff, tick_in;
   count_type byte_pos_ff, byte_pos_in;
   logic [2:0] bit_pos_ff, bit_pos_in;
   logic [7:0] repeats_ff, repeats_in;
   count_type send_len_ff, send_len_in;
   byte_type  shift_ff, shift_in;
   byte_type  first0_ff, first0_in;

   tick_type  tick_plus;
   logic      bit_end;
   logic      gap_end;
   logic      load_ok;
   logic      idle;
   logic      frame_begin;
   logic      byte_step;
   logic      seq_end;
   logic [15:0] bit_hold;

   assign idle = (phase_ff == PH_IDLE);
   assign tick_plus = tick_ff + TICK_W'(1);
   assign bit_end = (tick_plus >= TICK_W'(cfg.period_ticks));
   assign gap_end = (tick_plus >= cfg.reset_ticks);
   assign load_ok = ({1'b0, req_index} < COUNT_W'(MAX_BYTES));

   // next state
   always_comb begin
      phase_in = phase_ff;
      tick_in = tick_ff;
      byte_pos_in = byte_pos_ff;
      bit_pos_in = bit_pos_ff;
      repeats_in = repeats_ff;
      send_len_in = send_len_ff;
      shift_in = shift_ff;
      first0_in = first0_ff;
      frame_begin = 1'b0;
      byte_step = 1'b0;
      seq_end = 1'b0;
      if (item_valid) begin
         case (req_kind)
            KIND_LOAD: begin
               if (idle && load_ok && (req_index == '0)) begin
                  first0_in = req_byte_value;
               end
            end
            KIND_START: begin
               if (idle) begin
                  send_len_in = (req_count > COUNT_W'(MAX_BYTES)) ?
                                COUNT_W'(MAX_BYTES) : req_count;
                  phase_in = PH_LEAD;
                  tick_in = '0;
                  byte_pos_in = '0;
                  bit_pos_in = '0;
                  repeats_in = '0;
               end
            end
            KIND_TICK: begin
               case (phase_ff)
                  PH_IDLE: ;
                  PH_BITS: begin
                     if (!bit_end) begin
                        tick_in = tick_plus;
                     end else begin
                        tick_in = '0;
                        bit_pos_in = bit_pos_ff + 3'd1;
                        shift_in = {shift_ff[6:0], 1'b0};
                        if (bit_pos_ff == 3'd7) begin
                           // prefetched byte from the store
                           byte_step = 1'b1;
                           byte_pos_in = byte_pos_ff + COUNT_W'(1);
                           shift_in = ram_rd_data;
                           if (byte_pos_in >= send_len_ff) begin
                              phase_in = PH_GAP;
                           end
                        end
                     end
                  end
                  PH_LEAD: begin
                     if (!gap_end) begin
                        tick_in = tick_plus;
                     end else begin
                        tick_in = '0;
                        if (send_len_ff == '0) begin
                           phase_in = PH_IDLE;
                           seq_end = 1'b1;
                        end else begin
                           repeats_in = '0;
                           if (cfg.frame_repeats == '0) begin
                              phase_in = PH_TRAIL;
                           end else begin
                              frame_begin = 1'b1;
                           end
                        end
                     end
                  end
                  PH_GAP: begin
                     if (!gap_end) begin
                        tick_in = tick_plus;
                     end else begin
                        tick_in = '0;
                        repeats_in = repeats_ff + 8'd1;
                        if (repeats_in >= cfg.frame_repeats) begin
                           phase_in = PH_TRAIL;
                        end else begin
                           frame_begin = 1'b1;
                        end
                     end
                  end
                  PH_TRAIL: begin
                     if (!gap_end) begin
                        tick_in = tick_plus;
                     end else begin
                        tick_in = '0;
                        phase_in = PH_IDLE;
                        seq_end = 1'b1;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
               if (frame_begin) begin
                  phase_in = PH_BITS;
                  tick_in = '0;
                  byte_pos_in = '0;
                  bit_pos_in = '0;
                  shift_in = first0_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // outputs
   always_comb begin
      bit_hold = shift_in[7] ? cfg.high_one_ticks : cfg.high_zero_ticks;
      rsp.pin_level = (phase_in == PH_BITS) && (tick_in < TICK_W'(bit_hold));
      rsp.busy_res = (phase_in != PH_IDLE);
      rsp.accepted = item_valid && idle &&
                     (((req_kind == KIND_LOAD) && load_ok) || (req_kind == KIND_START));
      rsp.done_res = seq_end;
      ram_req.wr_en = item_valid && idle && (req_kind == KIND_LOAD) && load_ok;
      ram_req.wr_addr = req_index;
      ram_req.wr_data = req_byte_value;
      // keep the byte after the one now going out in the read register
      ram_req.rd_en = frame_begin || byte_step;
      ram_req.rd_addr = frame_begin ? ADDR_W'(1) : ADDR_W'(byte_pos_ff + COUNT_W'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff <= '0;
         byte_pos_ff <= '0;
         bit_pos_ff <= '0;
         repeats_ff <= '0;
         send_len_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff <= tick_in;
         byte_pos_ff <= byte_pos_in;
         bit_pos_ff <= bit_pos_in;
         repeats_ff <= repeats_in;
         send_len_ff <= send_len_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      first0_ff <= first0_in;
   end

`ifndef SYNTHESIS
   a_bits_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BITS) |-> (byte_pos_ff < send_len_ff))
      else $error("byte position past send length while sending bits");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (item_valid && seq_end) |=> (phase_ff == PH_IDLE))
      else $error("done pulse without return to idle");
   a_start_lead: assert property (@(posedge clock) disable iff (reset)
      (item_valid && (req_kind == KIND_START) && (phase_ff == PH_IDLE))
      |=> (phase_ff == PH_LEAD))
      else $error("start taken without opening reset gap");
`endif

endmodule

// ----- src/aled_rsp_buf.sv -----
module aled_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  aled_pkg::rsp_type push_data,
   output logic              in_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aled_pkg::rsp_type rsp_data
);

   import aled_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    out_fire;

   assign out_fire = main_valid_ff && rsp_ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (out_fire) begin
         if (skid_valid_ff) begin
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data = main_ff;

`ifndef SYNTHESIS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output register");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("beat pushed into full buffer");
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && main_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("beat lost while output stalled");
`endif

endmodule

// ----- src/addressable_led_serial_encoder.sv -----
// channel | direction | handshake             | payload
// req     | in        | req_valid/req_ready   | req_kind, req_index, req_byte_value, req_count
// rsp     | out       | rsp_valid/rsp_ready   | rsp_pin_level, rsp_busy_res, rsp_accepted,
//         |           |                       | rsp_done_res
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// one beat per cycle while req_ready is high: each req beat is worked in one pass and its rsp beat
// is registered, showing up the cycle after acceptance when the output is not stalled.
// a two-entry output buffer keeps req open while one rsp beat is stalled.
// the frame store is a 512 x 8 ram; the next byte is prefetched through its
// registered read port, so no bubbles appear at byte boundaries.
// reset (synchronous) returns the sequencer to idle; store contents persist.
// csr writes are always taken and apply from the next beat.
module addressable_led_serial_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [8:0]                       req_index,
   input  logic [7:0]                       req_byte_value,
   input  logic [9:0]                       req_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_pin_level,
   output logic                             rsp_busy_res,
   output logic                             rsp_accepted,
   output logic                             rsp_done_res,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [aled_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aled_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import aled_pkg::*;

   cfg_type     cfg;
   ram_req_type ram_req;
   byte_type    ram_rd_data;
   rsp_type     core_rsp;
   rsp_type     out_rsp;
   logic        item_valid;
   logic        buf_ready;

   assign req_ready = buf_ready;
   assign item_valid = req_valid && buf_ready;

   aled_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aled_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   aled_core u_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .req_kind       (req_kind),
      .req_index      (req_index),
      .req_byte_value (req_byte_value),
      .req_count      (req_count),
      .cfg            (cfg),
      .ram_rd_data    (ram_rd_data),
      .ram_req        (ram_req),
      .rsp            (core_rsp)
   );

   aled_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (item_valid),
      .push_data (core_rsp),
      .in_ready  (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_rsp)
   );

   assign rsp_pin_level = out_rsp.pin_level;
   assign rsp_busy_res = out_rsp.busy_res;
   assign rsp_accepted = out_rsp.accepted;
   assign rsp_done_res = out_rsp.done_res;

endmodule

// ----- tb/led_line_checker.sv -----
module led_line_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [8:0]                       req_index,
   input  logic [7:0]                       req_byte_value,
   input  logic [9:0]                       req_count,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_pin_level,
   input  logic                             rsp_busy_res,
   input  logic                             rsp_accepted,
   input  logic                             rsp_done_res,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [aled_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aled_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               mismatches,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import aled_pkg::*;

   byte_type  frame_bytes [MAX_BYTES];
   cfg_type   cfg;
   phase_type ph;
   tick_type  tcnt;
   count_type byte_at;
   logic [2:0] bit_at;
   logic [7:0] sends_done;
   count_type send_len;
   rsp_type   line_states [$];
   int        rsp_beats;

   task automatic report(input string msg);
      if (mismatches < 40) begin
         $display("%t mismatch: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   function automatic logic [15:0] bit_high_time();
      byte_type b;
      b = frame_bytes[(byte_at < MAX_BYTES) ? byte_at[ADDR_W-1:0] : '0];
      return b[3'd7 - bit_at] ? cfg.high_one_ticks : cfg.high_zero_ticks;
   endfunction

   function automatic void restart_frame();
      ph = PH_BITS;
      tcnt = '0;
      byte_at = '0;
      bit_at = '0;
   endfunction

   // one tick of line time; returns 1 when the sequence finishes
   function automatic logic tick_line();
      if (ph == PH_IDLE) return 1'b0;
      tcnt = tcnt + 1'b1;
      if (ph == PH_BITS) begin
         if (tcnt < cfg.period_ticks) return 1'b0;
         tcnt = '0;
         bit_at = bit_at + 1'b1;
         if (bit_at == 3'd0) begin
            byte_at = byte_at + 1'b1;
            if (byte_at >= send_len) ph = PH_GAP;
         end
         return 1'b0;
      end
      if (tcnt < cfg.reset_ticks) return 1'b0;
      tcnt = '0;
      case (ph)
         PH_LEAD: begin
            if (send_len == '0) begin
               ph = PH_IDLE;
               return 1'b1;
            end
            sends_done = '0;
            if (cfg.frame_repeats == '0) ph = PH_TRAIL;
            else restart_frame();
         end
         PH_GAP: begin
            sends_done = sends_done + 1'b1;
            if (sends_done >= cfg.frame_repeats) ph = PH_TRAIL;
            else restart_frame();
         end
         default: begin
            ph = PH_IDLE;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic rsp_type encode_step(input logic [1:0] kind, input addr_type idx,
                                           input byte_type val, input count_type cnt);
      rsp_type r;
      r = '0;
      case (kind)
         KIND_LOAD: begin
            if (ph == PH_IDLE) begin
               frame_bytes[idx] = val;
               r.accepted = 1'b1;
            end
         end
         KIND_START: begin
            if (ph == PH_IDLE) begin
               send_len = (cnt > MAX_BYTES) ? count_type'(MAX_BYTES) : cnt;
               ph = PH_LEAD;
               tcnt = '0;
               byte_at = '0;
               bit_at = '0;
               sends_done = '0;
               r.accepted = 1'b1;
            end
         end
         KIND_TICK: r.done_res = tick_line();
         default: ;
      endcase
      r.pin_level = (ph == PH_BITS) && (tcnt < bit_high_time());
      r.busy_res = (ph != PH_IDLE);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         cfg.period_ticks = 16'd225;
         cfg.high_zero_ticks = 16'd63;
         cfg.high_one_ticks = 16'd126;
         cfg.reset_ticks = 20'd18000;
         cfg.frame_repeats = 8'd1;
         ph = PH_IDLE;
         tcnt = '0;
         byte_at = '0;
         bit_at = '0;
         sends_done = '0;
         send_len = '0;
         line_states.delete();
         rsp_beats = 0;
      end else begin
         if (req_valid && req_ready) begin
            line_states.push_back(encode_step(req_kind, req_index, req_byte_value,
                                              req_count));
         end
         // register writes apply from the next beat on
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PERIOD:      cfg.period_ticks = csr_wdata[15:0];
               CSR_HIGH_ZERO:   cfg.high_zero_ticks = csr_wdata[15:0];
               CSR_HIGH_ONE:    cfg.high_one_ticks = csr_wdata[15:0];
               CSR_RESET_TICKS: cfg.reset_ticks = csr_wdata[TICK_W-1:0];
               CSR_REPEATS:     cfg.frame_repeats = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pin_level, rsp_busy_res, rsp_accepted, rsp_done_res};
            if (line_states.size() == 0) begin
               report($sformatf("rsp beat %0d arrived with nothing outstanding", rsp_beats));
            end else begin
               want = line_states.pop_front();
               if (got.pin_level !== want.pin_level)
                  report($sformatf("rsp beat %0d pin_level %b, wanted %b", rsp_beats,
                                   got.pin_level, want.pin_level));
               if (got.busy_res !== want.busy_res)
                  report($sformatf("rsp beat %0d busy_res %b, wanted %b", rsp_beats,
                                   got.busy_res, want.busy_res));
               if (got.accepted !== want.accepted)
                  report($sformatf("rsp beat %0d accepted %b, wanted %b", rsp_beats,
                                   got.accepted, want.accepted));
               if (got.done_res !== want.done_res)
                  report($sformatf("rsp beat %0d done_res %b, wanted %b", rsp_beats,
                                   got.done_res, want.done_res));
            end
            rsp_beats++;
         end
      end
      pending = line_states.size();
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import aled_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 650;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = KIND_TICK;
   addr_type req_index = '0;
   byte_type req_byte_value = '0;
   count_type req_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_pin_level;
   logic rsp_busy_res;
   logic rsp_accepted;
   logic rsp_done_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PERIOD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int pending;

   cfg_type line_cfg;
   bit loaded [MAX_BYTES];
   bit quiet = 1'b0;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int items_sent = 0;
   int cycles = 0;

   addressable_led_serial_encoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_index(req_index), .req_byte_value(req_byte_value), .req_count(req_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pin_level(rsp_pin_level),
      .rsp_busy_res(rsp_busy_res), .rsp_accepted(rsp_accepted),
      .rsp_done_res(rsp_done_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   led_line_checker watch (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_index(req_index), .req_byte_value(req_byte_value), .req_count(req_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pin_level(rsp_pin_level),
      .rsp_busy_res(rsp_busy_res), .rsp_accepted(rsp_accepted),
      .rsp_done_res(rsp_done_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stalls in bursts of random length
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [1:0] kind, input addr_type idx,
                            input byte_type val, input count_type cnt);
      int gap;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_index <= idx;
      req_byte_value <= val;
      req_count <= cnt;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic load_byte(input int idx, input int val);
      send_item(KIND_LOAD, addr_type'(idx), byte_type'(val), count_type'($urandom));
      loaded[idx] = 1'b1;
   endtask

   // items the block must refuse or ignore while a sequence runs
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_item(KIND_LOAD, addr_type'($urandom), byte_type'($urandom),
                      count_type'($urandom));
         1: send_item(KIND_START, addr_type'($urandom), byte_type'($urandom),
                      count_type'($urandom));
         default: send_item(KIND_UNUSED, addr_type'($urandom), byte_type'($urandom),
                            count_type'($urandom));
      endcase
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_config(input int period, input int hzero, input int hone,
                             input int gap, input int reps);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(CSR_PERIOD, period);
      write_reg(CSR_HIGH_ZERO, hzero);
      write_reg(CSR_HIGH_ONE, hone);
      write_reg(CSR_RESET_TICKS, gap);
      write_reg(CSR_REPEATS, reps);
      csr_valid <= 1'b0;
      line_cfg.period_ticks = 16'(period);
      line_cfg.high_zero_ticks = 16'(hzero);
      line_cfg.high_one_ticks = 16'(hone);
      line_cfg.reset_ticks = TICK_W'(gap);
      line_cfg.frame_repeats = 8'(reps);
   endtask

   // ticks from start until the sequence ends
   function automatic int sequence_ticks(input int n);
      int p;
      int r;
      int total;
      p = (line_cfg.period_ticks == 0) ? 1 : int'(line_cfg.period_ticks);
      r = (line_cfg.reset_ticks == 0) ? 1 : int'(line_cfg.reset_ticks);
      total = r;
      if (n > 0) total += int'(line_cfg.frame_repeats) * (n * 8 * p + r) + r;
      return total;
   endfunction

   // fills any unloaded byte the frame will read, starts, then ticks to the end
   task automatic run_sequence(input int n, input int noise_pct);
      int cnt;
      int ticks;
      if ($urandom_range(0, 3) == 0) begin
         send_item(KIND_TICK, addr_type'($urandom), byte_type'($urandom),
                   count_type'($urandom));
      end
      for (int i = 0; i < n; i++) begin
         if (!loaded[i] || $urandom_range(0, 3) == 0) load_byte(i, $urandom_range(0, 255));
      end
      repeat ($urandom_range(0, 2)) load_byte($urandom_range(0, MAX_BYTES - 1),
                                              $urandom_range(0, 255));
      cnt = (n == MAX_BYTES) ? $urandom_range(MAX_BYTES, 1023) : n;
      send_item(KIND_START, addr_type'($urandom), byte_type'($urandom), count_type'(cnt));
      ticks = sequence_ticks(n);
      repeat (ticks) begin
         if ($urandom_range(0, 99) < noise_pct) send_noise();
         send_item(KIND_TICK, addr_type'($urandom), byte_type'($urandom),
                   count_type'($urandom));
      end
   endtask

   task automatic pick_idling();
      case ($urandom_range(0, 2))
         0: gap_pct = 0;
         1: gap_pct = 15;
         default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
         0: stall_pct = 0;
         1: stall_pct = 15;
         default: stall_pct = 40;
      endcase
   endtask

   initial begin
      int first_random;
      int n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register extremes, with the block left idle
      pick_idling();
      set_config(65535, 65535, 65535, 1048575, 255);
      send_item(KIND_TICK, '1, '1, '1);
      send_item(KIND_UNUSED, '0, '0, '0);
      load_byte(MAX_BYTES - 1, 8'hFF);
      load_byte(0, 8'h00);

      set_config(4, 1, 3, 2, 1);
      load_byte(1, 8'hA5);
      load_byte(2, 8'hFF);
      run_sequence(3, 30);
      run_sequence(0, 30);
      // one bits high for the whole period
      set_config(3, 1, 65535, 1, 2);
      run_sequence(2, 10);
      // zero bits high for the whole period
      set_config(2, 2, 1, 1, 1);
      run_sequence(1, 10);
      pick_idling();
      set_config(2, 1, 1, 1, 255);
      run_sequence(1, 0);
      // start count above the store size saturates
      set_config(2, 1, 2, 1, 1);
      run_sequence(MAX_BYTES, 2);

      first_random = items_sent;
      while (items_sent < first_random + RANDOM_ITEMS) begin
         quiet = (items_sent >= first_random + RANDOM_ITEMS * 85 / 100);
         pick_idling();
         if ($urandom_range(0, 1) == 0) begin
            set_config($urandom_range(2, 6), $urandom_range(1, 8), $urandom_range(1, 8),
                       $urandom_range(1, 10), $urandom_range(1, 3));
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
         run_sequence(n, $urandom_range(0, 25));
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/aled_pkg.sv
src/aled_ram.sv
src/aled_csr.sv
src/aled_core.sv
src/aled_rsp_buf.sv
src/addressable_led_serial_encoder.sv
tb/led_line_checker.sv
tb/tb_top.sv
